/* design/smsf_pkg.sv */
// shared types and constant marker tables for the stop marker stream filter
package smsf_pkg;

   typedef logic [7:0] byte_type;

   localparam int MAX_USER      = 4;
   localparam int FIXED_MARKERS = 6;
   localparam int MK_COUNT      = MAX_USER + FIXED_MARKERS;
   localparam int MAX_MK_LEN    = 13;

   localparam logic [3:0] MK_FIRST_FIXED = 4'd4;
   localparam logic [3:0] MK_THINK_OPEN  = 4'd7;
   localparam logic [3:0] MK_THINK_CLOSE = 4'd8;
   localparam logic [3:0] MK_LAST        = 4'd9;

   localparam logic [3:0] LEN_THINK_OPEN  = 4'd7;
   localparam logic [3:0] LEN_THINK_CLOSE = 4'd8;

   // csr register indexes
   localparam logic [2:0] CSR_THINK   = 3'd0;
   localparam logic [2:0] CSR_MARK0   = 3'd1;
   localparam logic [2:0] CSR_MARK3   = 3'd4;
   localparam logic [2:0] CSR_LENGTHS = 3'd5;

   // request kinds
   localparam logic REQ_TEXT  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam byte_type REPL_SEQ [3] = '{8'hEF, 8'hBF, 8'hBD};

   localparam byte_type FIXED_TEXT [FIXED_MARKERS][MAX_MK_LEN] = '{
      '{8'h3C, 8'h7C, 8'h69, 8'h6D, 8'h5F, 8'h65, 8'h6E, 8'h64, 8'h7C, 8'h3E,
        8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h7C, 8'h65, 8'h6E, 8'h64, 8'h6F, 8'h66, 8'h74, 8'h65, 8'h78,
        8'h74, 8'h7C, 8'h3E},
      '{8'h3C, 8'h2F, 8'h73, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h2F, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00},
      '{8'hEF, 8'hBF, 8'hBD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] FIXED_LEN [FIXED_MARKERS] =
      '{4'd10, 4'd13, 4'd4, 4'd7, 4'd8, 4'd3};

   // one request to the output stage
   typedef struct packed {
      logic     push;
      logic     fin;
      logic     hit;
      byte_type data;
   } emit_type;

endpackage

/* design/stop_marker_stream_filter.sv */
// top level: hold buffer, sequencer and csr bank of the stop marker stream filter
//
// usage
//   req channel: one transfer per text byte (tuser 0) or flush (tuser 1), tdata = byte
//   rsp channel: one transfer per released byte; tuser[0] has_byte, tuser[1] stop_hit,
//     tlast on the final transfer of each request; a request that releases nothing
//     gives one transfer with has_byte 0
//   csr port: write-only, index 0 think enable, 1..4 user markers, 5 marker lengths
// timing
//   one request at a time; req_tready is high only while the sequencer is idle
//   a text byte first checks the last three held bytes for the replacement
//   character, then runs the release loop: each pass steps through every marker
//   one at a time in the shared compare unit and then decides to release or drop
//   one byte, strip a think marker or finish; a flush releases or drops its held
//   bytes, then finishes; the compare unit is shared by all ten markers
// reset
//   synchronous, clears the sequencer, held count, think and stop flags and csrs
// stall
//   a stalled rsp side holds the output register; the sequencer waits on it
module stop_marker_stream_filter #(
   parameter int USER_MARKERS      = 4,
   parameter int USER_MARKER_BYTES = 8,
   parameter int HOLD_DEPTH        = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [0:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic [1:0]  rsp_tuser,   // has_byte, stop_hit
   output logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import smsf_pkg::*;

   localparam int CW = $clog2(HOLD_DEPTH+1);
   localparam int AW = $clog2(HOLD_DEPTH);
   localparam int MW = USER_MARKER_BYTES*8;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REPL   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   // csr bank
   logic          think_en_ff;
   logic [MW-1:0] umark_ff [MAX_USER];
   logic [15:0]   ulens_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         think_en_ff <= 1'b0;
         ulens_ff    <= 16'h0;
         for (int k = 0; k < MAX_USER; k++) umark_ff[k] <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_THINK) think_en_ff <= csr_wdata[0];
         if (csr_index == CSR_LENGTHS) ulens_ff <= csr_wdata[15:0];
         if (csr_index >= CSR_MARK0 && csr_index <= CSR_MARK3 &&
             int'(csr_index - CSR_MARK0) < USER_MARKERS) begin
            umark_ff[2'(csr_index - CSR_MARK0)] <= csr_wdata[MW-1:0];
         end
      end
   end

   // sequencer state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   byte_type      held_ff [HOLD_DEPTH];
   byte_type      held_in [HOLD_DEPTH];
   byte_type      shifted [HOLD_DEPTH];
   logic [3:0]    sh;
   logic [3:0]    idx_ff, idx_in;
   logic          in_think_ff, in_think_in;
   logic          stopped_ff, stopped_in;
   logic          repl_ok_ff, repl_ok_in;
   logic          hit_ff, hit_in;
   logic          open_ff, open_in;
   logic          close_ff, close_in;
   logic          wait_ff, wait_in;
   logic          drop_ff, drop_in;
   logic          starts, partial;
   logic          out_ready;
   emit_type      emit;
   logic [AW-1:0] rd_addr;
   logic          think_off;

   assign think_off  = !think_en_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rd_addr    = AW'(cnt_ff - CW'(3) + CW'(idx_ff));

   smsf_match #(
      .USER_MARKERS      (USER_MARKERS),
      .USER_MARKER_BYTES (USER_MARKER_BYTES),
      .HOLD_DEPTH        (HOLD_DEPTH)
   ) u_match (
      .held       (held_ff),
      .held_count (cnt_ff),
      .mk_sel     (idx_ff),
      .user_mark  (umark_ff),
      .user_lens  (ulens_ff),
      .starts     (starts),
      .partial    (partial)
   );

   // drop the front sh bytes of the hold buffer
   always_comb begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (i + int'(sh) < HOLD_DEPTH) shifted[i] = held_ff[AW'(i + int'(sh))];
         else shifted[i] = held_ff[i];
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      held_in     = held_ff;
      idx_in      = idx_ff;
      in_think_in = in_think_ff;
      stopped_in  = stopped_ff;
      repl_ok_in  = repl_ok_ff;
      hit_in      = hit_ff;
      open_in     = open_ff;
      close_in    = close_ff;
      wait_in     = wait_ff;
      drop_in     = drop_ff;
      sh          = 4'd1;
      emit        = '0;
      emit.data   = held_ff[0];
      emit.hit    = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            hit_in = 1'b0;
            if (req_tvalid) begin
               if (req_tuser[0] == REQ_FLUSH) begin
                  drop_in  = stopped_ff || in_think_ff;
                  state_in = ST_FLUSH;
               end else if (stopped_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  // append, discarding the oldest byte if full
                  if (cnt_ff == CW'(HOLD_DEPTH)) begin
                     held_in = shifted;
                     held_in[HOLD_DEPTH-1] = req_tdata;
                  end else begin
                     held_in[cnt_ff[AW-1:0]] = req_tdata;
                     cnt_in = cnt_ff + CW'(1);
                  end
                  idx_in     = 4'd0;
                  repl_ok_in = 1'b1;
                  state_in   = ST_REPL;
               end
            end
         end
         ST_REPL: begin
            // check the last three held bytes for the replacement character
            if (cnt_ff < CW'(3) || held_ff[rd_addr] != REPL_SEQ[idx_ff[1:0]]) begin
               repl_ok_in = 1'b0;
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd2) begin
               if (repl_ok_in) cnt_in = cnt_ff - CW'(3);
               idx_in   = 4'd0;
               open_in  = 1'b0;
               close_in = 1'b0;
               wait_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (starts && idx_ff < MK_THINK_OPEN) hit_in = 1'b1;
            if (starts && idx_ff == MK_THINK_OPEN) open_in = 1'b1;
            if (starts && idx_ff == MK_THINK_CLOSE) close_in = 1'b1;
            if (partial && !(!think_off &&
                (idx_ff == MK_THINK_OPEN || idx_ff == MK_THINK_CLOSE))) begin
               wait_in = 1'b1;
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == MK_LAST) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            idx_in   = 4'd0;
            open_in  = 1'b0;
            close_in = 1'b0;
            wait_in  = 1'b0;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (hit_ff) begin
               stopped_in = 1'b1;
               cnt_in     = '0;
               state_in   = ST_FINISH;
            end else if (think_off && !in_think_ff && open_ff) begin
               sh          = LEN_THINK_OPEN;
               held_in     = shifted;
               cnt_in      = cnt_ff - CW'(LEN_THINK_OPEN);
               in_think_in = 1'b1;
               state_in    = ST_SCAN;
            end else if (think_off && in_think_ff && close_ff) begin
               sh          = LEN_THINK_CLOSE;
               held_in     = shifted;
               cnt_in      = cnt_ff - CW'(LEN_THINK_CLOSE);
               in_think_in = 1'b0;
               state_in    = ST_SCAN;
            end else if (wait_ff) begin
               state_in = ST_FINISH;
            end else if (in_think_ff || out_ready) begin
               emit.push = !in_think_ff;
               held_in   = shifted;
               cnt_in    = cnt_ff - CW'(1);
               state_in  = ST_SCAN;
            end else begin
               // output stalled: keep the decision flags and retry
               open_in  = open_ff;
               close_in = close_ff;
               wait_in  = wait_ff;
            end
         end
         ST_FLUSH: begin
            if (cnt_ff == '0 || drop_ff) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else if (out_ready) begin
               emit.push = 1'b1;
               held_in   = shifted;
               cnt_in    = cnt_ff - CW'(1);
            end
         end
         ST_FINISH: begin
            if (out_ready) begin
               emit.fin = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         in_think_ff <= 1'b0;
         stopped_ff  <= 1'b0;
         idx_ff      <= 4'd0;
         hit_ff      <= 1'b0;
         open_ff     <= 1'b0;
         close_ff    <= 1'b0;
         wait_ff     <= 1'b0;
         drop_ff     <= 1'b0;
         repl_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         in_think_ff <= in_think_in;
         stopped_ff  <= stopped_in;
         idx_ff      <= idx_in;
         hit_ff      <= hit_in;
         open_ff     <= open_in;
         close_ff    <= close_in;
         wait_ff     <= wait_in;
         drop_ff     <= drop_in;
         repl_ok_ff  <= repl_ok_in;
      end
      held_ff <= held_in;
   end

   smsf_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .ready      (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/smsf_match.sv */
// compare unit: matches the head of the hold buffer against one selected marker
module smsf_match #(
   parameter int USER_MARKERS      = 4,
   parameter int USER_MARKER_BYTES = 8,
   parameter int HOLD_DEPTH        = 16
) (
   input  smsf_pkg::byte_type              held [HOLD_DEPTH],
   input  logic [$clog2(HOLD_DEPTH+1)-1:0] held_count,
   input  logic [3:0]                      mk_sel,
   input  logic [USER_MARKER_BYTES*8-1:0]  user_mark [smsf_pkg::MAX_USER],
   input  logic [15:0]                     user_lens,
   output logic                            starts,
   output logic                            partial
);
   import smsf_pkg::*;

   localparam int CW = $clog2(HOLD_DEPTH+1);

   byte_type   mk_byte [MAX_MK_LEN];
   logic [3:0] mk_len;
   logic [3:0] raw_len;
   logic       len_ok;
   logic       cnt_ok;

   always_comb begin
      raw_len = 4'd0;
      mk_len  = 4'd0;
      for (int i = 0; i < MAX_MK_LEN; i++) begin
         mk_byte[i] = 8'h00;
      end
      if (mk_sel < MK_FIRST_FIXED) begin
         raw_len = user_lens[4*mk_sel[1:0] +: 4];
         if (int'(mk_sel) >= USER_MARKERS) begin
            mk_len = 4'd0;
         end else if (raw_len > 4'(USER_MARKER_BYTES)) begin
            mk_len = 4'(USER_MARKER_BYTES);
         end else begin
            mk_len = raw_len;
         end
         for (int i = 0; i < USER_MARKER_BYTES; i++) begin
            mk_byte[i] = user_mark[mk_sel[1:0]][8*i +: 8];
         end
      end else if (mk_sel <= MK_LAST) begin
         mk_len = FIXED_LEN[3'(mk_sel - MK_FIRST_FIXED)];
         for (int i = 0; i < MAX_MK_LEN; i++) begin
            mk_byte[i] = FIXED_TEXT[3'(mk_sel - MK_FIRST_FIXED)][i];
         end
      end
   end

   // prefix compare over the marker length and over the held count
   always_comb begin
      len_ok = 1'b1;
      cnt_ok = 1'b1;
      for (int i = 0; i < MAX_MK_LEN; i++) begin
         if (held[i] != mk_byte[i]) begin
            if (i < int'(mk_len)) len_ok = 1'b0;
            if (i < int'(held_count)) cnt_ok = 1'b0;
         end
      end
      starts  = (mk_len != 4'd0) && (held_count >= CW'(mk_len)) && len_ok;
      partial = (held_count != '0) && (held_count < CW'(mk_len)) && cnt_ok;
   end

endmodule

/* design/smsf_out.sv */
// output stage: keeps the newest released byte back so the final one carries tlast
module smsf_out (
   input  logic               clock,
   input  logic               reset,
   input  smsf_pkg::emit_type emit,
   output logic               ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import smsf_pkg::*;

   logic     valid_ff, valid_in;
   logic     pend_v_ff, pend_v_in;
   byte_type pend_ff, pend_in;
   byte_type data_ff, data_in;
   logic     has_ff, has_in;
   logic     hit_ff, hit_in;
   logic     last_ff, last_in;

   assign ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      data_in   = data_ff;
      has_in    = has_ff;
      hit_in    = hit_ff;
      last_in   = last_ff;
      if (ready && emit.push) begin
         if (pend_v_ff) begin
            valid_in = 1'b1;
            data_in  = pend_ff;
            has_in   = 1'b1;
            hit_in   = 1'b0;
            last_in  = 1'b0;
         end
         pend_v_in = 1'b1;
         pend_in   = emit.data;
      end else if (ready && emit.fin) begin
         valid_in  = 1'b1;
         data_in   = pend_v_ff ? pend_ff : 8'h00;
         has_in    = pend_v_ff;
         hit_in    = emit.hit;
         last_in   = 1'b1;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         pend_v_ff <= pend_v_in;
      end
      pend_ff <= pend_in;
      data_ff <= data_in;
      has_ff  <= has_in;
      hit_ff  <= hit_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {hit_ff, has_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* design/smsf_checker.sv */
// port checker for the stop marker stream filter and its bind
module smsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // an empty result is always the final one and carries zero data
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("empty result not final or nonzero");

   // stop hit only on a final result
   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("stop hit on non-final result");

   // one request at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind stop_marker_stream_filter smsf_checker u_smsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
